### design/prdt_pkg.sv
// Package for the periodic release and deadline timer.
// Holds sizes, operation and status codes, state type and controller/datapath structs.
package prdt_pkg;
    localparam int PerSlots   = 16;
    localparam int DlSlots    = 16;
    localparam int CountBits  = 16;
    localparam int SlotBits   = 4;
    localparam int PerIdxBits = (PerSlots > 1) ? $clog2(PerSlots) : 1;
    localparam int DlIdxBits  = (DlSlots > 1) ? $clog2(DlSlots) : 1;
    localparam logic [7:0] LevelMax = 8'd255;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_CREATE_P = 3'd1,
        FN_CREATE_D = 3'd2,
        FN_JOB_DONE = 3'd3,
        FN_START    = 3'd4,
        FN_STOP     = 3'd5,
        FN_FREE_P   = 3'd6,
        FN_FREE_D   = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_USED = 2'd1,
        ST_ZERO_PER = 2'd2,
        ST_LIMIT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_PER_WALK,
        S_DL_WALK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic do_op;     // execute a non-tick operation
        logic clr_acc;   // clear tick accumulators
        logic per_step;  // process one periodic slot
        logic dl_step;   // process one deadline slot
        logic finish;    // form the result item
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic per_last;
        logic dl_last;
    } t_stat;
endpackage

### design/prdt_if.sv
// Valid/ready channel interfaces for the timer.
// Depends on prdt_pkg.
interface prdt_in_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      func;
    logic [3:0]                      slot;
    logic [prdt_pkg::CountBits-1:0]  count_value;
    logic [7:0]                      priority_req;
    logic [7:0]                      active_priority;
    logic                            active_has_deadline;
    modport source (output valid, func, slot, count_value, priority_req, active_priority,
                    active_has_deadline, input ready);
    modport sink (input valid, func, slot, count_value, priority_req, active_priority,
                  active_has_deadline, output ready);
endinterface

interface prdt_out_if;
    logic       valid;
    logic       ready;
    logic       preempt;
    logic [4:0] released_count;
    logic [4:0] new_misses;
    logic       still_ready;
    logic [7:0] level;
    logic [1:0] status;
    modport source (output valid, preempt, released_count, new_misses, still_ready, level,
                    status, input ready);
    modport sink (input valid, preempt, released_count, new_misses, still_ready, level,
                  status, output ready);
endinterface

### design/prdt_ctrl.sv
// Controller state machine for the timer.
// Depends on prdt_pkg.
module prdt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  prdt_pkg::t_stat  i_stat,
    output prdt_pkg::t_cmd   o_cmd
);
    prdt_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prdt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = prdt_pkg::S_OP;
            end
            prdt_pkg::S_OP: begin
                n_state = i_stat.is_tick ? prdt_pkg::S_PER_WALK : prdt_pkg::S_DONE;
            end
            prdt_pkg::S_PER_WALK: begin
                if (i_stat.per_last) n_state = prdt_pkg::S_DL_WALK;
            end
            prdt_pkg::S_DL_WALK: begin
                if (i_stat.dl_last) n_state = prdt_pkg::S_DONE;
            end
            prdt_pkg::S_DONE: begin
                if (i_out_ready) n_state = prdt_pkg::S_IDLE;
            end
            default: n_state = prdt_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            prdt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            prdt_pkg::S_OP: begin
                o_cmd.do_op   = !i_stat.is_tick;
                o_cmd.clr_acc = 1'b1;
            end
            prdt_pkg::S_PER_WALK: o_cmd.per_step = 1'b1;
            prdt_pkg::S_DL_WALK: begin
                o_cmd.dl_step = 1'b1;
                o_cmd.finish  = i_stat.dl_last;
            end
            prdt_pkg::S_DONE: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

### design/prdt_datapath.sv
// Datapath of the timer: slot tables, the per-slot tick unit and result registers.
// Depends on prdt_pkg.
module prdt_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prdt_pkg::t_cmd                  i_cmd,
    output prdt_pkg::t_stat                 o_stat,
    input  logic [2:0]                      i_func,
    input  logic [3:0]                      i_slot,
    input  logic [prdt_pkg::CountBits-1:0]  i_count_value,
    input  logic [7:0]                      i_priority_req,
    input  logic [7:0]                      i_active_priority,
    input  logic                            i_active_has_deadline,
    output logic                            o_preempt,
    output logic [4:0]                      o_released_count,
    output logic [4:0]                      o_new_misses,
    output logic                            o_still_ready,
    output logic [7:0]                      o_level,
    output logic [1:0]                      o_status
);
    localparam int CB = prdt_pkg::CountBits;

    // Slot tables; valid, suspended, pending and nesting are reset, the rest
    // are only read while valid or cleared on free.
    logic [prdt_pkg::PerSlots-1:0] r_per_valid, r_per_susp;
    logic [CB-1:0] r_per_reload [prdt_pkg::PerSlots];
    logic [CB-1:0] r_per_count  [prdt_pkg::PerSlots];
    logic [7:0]    r_per_prio   [prdt_pkg::PerSlots];
    logic [7:0]    r_per_pend   [prdt_pkg::PerSlots];
    logic [prdt_pkg::DlSlots-1:0]  r_dl_valid;
    logic [CB-1:0] r_dl_init    [prdt_pkg::DlSlots];
    logic [CB-1:0] r_dl_count   [prdt_pkg::DlSlots];
    logic [7:0]    r_dl_nest    [prdt_pkg::DlSlots];

    // Captured item.
    prdt_pkg::t_func r_func;
    logic [3:0]      r_slot;
    logic [CB-1:0]   r_cnt;
    logic [7:0]      r_prio, r_act_prio;
    logic            r_act_dl;

    // Walk index, accumulators and result.
    logic [prdt_pkg::PerIdxBits-1:0] r_pidx;
    logic [prdt_pkg::DlIdxBits-1:0]  r_didx;
    logic [4:0] r_rel, r_miss;
    logic       r_pre, r_sat;
    logic       r_preempt, r_still;
    logic [7:0] r_level;
    logic [1:0] r_status;

    assign o_stat.is_tick  = (r_func == prdt_pkg::FN_TICK);
    assign o_stat.per_last = (32'(r_pidx) == prdt_pkg::PerSlots - 1);
    assign o_stat.dl_last  = (32'(r_didx) == prdt_pkg::DlSlots - 1);

    // Slot addressing for operations.
    logic pok, dok, pv, dv;
    logic [prdt_pkg::PerIdxBits-1:0] ps;
    logic [prdt_pkg::DlIdxBits-1:0]  ds;
    assign pok = 32'(r_slot) < prdt_pkg::PerSlots;
    assign dok = 32'(r_slot) < prdt_pkg::DlSlots;
    assign ps  = prdt_pkg::PerIdxBits'(r_slot);
    assign ds  = prdt_pkg::DlIdxBits'(r_slot);
    assign pv  = pok && r_per_valid[ps];
    assign dv  = dok && r_dl_valid[ds];

    // Tick step for the current periodic slot.
    logic [CB-1:0] pdec;
    logic          pzero;
    assign pdec  = r_per_count[r_pidx] - 1'b1;
    assign pzero = r_per_valid[r_pidx] && (pdec == '0);

    logic dact;
    assign dact = r_dl_valid[r_didx] && (r_dl_nest[r_didx] != '0) &&
                  (r_dl_count[r_didx] != '0);

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= prdt_pkg::t_func'(i_func);
            r_slot     <= i_slot;
            r_cnt      <= i_count_value;
            r_prio     <= i_priority_req;
            r_act_prio <= i_active_priority;
            r_act_dl   <= i_active_has_deadline;
        end
    end

    // Operation execution, slot walks and result formation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_valid <= '0;
            r_per_susp  <= '0;
            r_dl_valid  <= '0;
            for (int i = 0; i < prdt_pkg::PerSlots; i++) r_per_pend[i] <= '0;
            for (int i = 0; i < prdt_pkg::DlSlots; i++)  r_dl_nest[i]  <= '0;
            r_pidx <= '0;
            r_didx <= '0;
        end else begin
            if (i_cmd.clr_acc) begin
                r_pidx <= '0;
                r_didx <= '0;
                r_rel  <= '0;
                r_miss <= '0;
                r_pre  <= 1'b0;
                r_sat  <= 1'b0;
            end
            if (i_cmd.do_op) begin
                r_preempt <= 1'b0;
                r_still   <= 1'b0;
                r_level   <= '0;
                r_status  <= prdt_pkg::ST_OK;
                case (r_func)
                    prdt_pkg::FN_CREATE_P: begin
                        if (!pok) r_status <= prdt_pkg::ST_NOT_USED;
                        else if (r_cnt == '0) r_status <= prdt_pkg::ST_ZERO_PER;
                        else begin
                            r_per_valid[ps]  <= 1'b1;
                            r_per_reload[ps] <= r_cnt;
                            r_per_count[ps]  <= r_cnt;
                            r_per_prio[ps]   <= r_prio;
                            r_per_susp[ps]   <= 1'b0;
                            r_per_pend[ps]   <= '0;
                        end
                    end
                    prdt_pkg::FN_CREATE_D: begin
                        if (!dok) r_status <= prdt_pkg::ST_NOT_USED;
                        else begin
                            r_dl_valid[ds] <= 1'b1;
                            r_dl_init[ds]  <= r_cnt;
                            r_dl_count[ds] <= r_cnt;
                            r_dl_nest[ds]  <= '0;
                        end
                    end
                    prdt_pkg::FN_JOB_DONE: begin
                        if (!pv) r_status <= prdt_pkg::ST_NOT_USED;
                        else if (r_per_pend[ps] == '0) r_per_susp[ps] <= 1'b1;
                        else begin
                            r_per_pend[ps] <= r_per_pend[ps] - 1'b1;
                            r_still        <= 1'b1;
                            r_level        <= r_per_pend[ps] - 1'b1;
                        end
                    end
                    prdt_pkg::FN_START: begin
                        if (!dv) r_status <= prdt_pkg::ST_NOT_USED;
                        else if (r_dl_nest[ds] == prdt_pkg::LevelMax) begin
                            r_level  <= r_dl_nest[ds];
                            r_status <= prdt_pkg::ST_LIMIT;
                        end else begin
                            r_dl_nest[ds] <= r_dl_nest[ds] + 1'b1;
                            r_level       <= r_dl_nest[ds] + 1'b1;
                        end
                    end
                    prdt_pkg::FN_STOP: begin
                        if (!dv) r_status <= prdt_pkg::ST_NOT_USED;
                        else if (r_dl_nest[ds] == '0) r_status <= prdt_pkg::ST_LIMIT;
                        else begin
                            r_dl_count[ds] <= r_dl_init[ds];
                            r_dl_nest[ds]  <= r_dl_nest[ds] - 1'b1;
                            r_level        <= r_dl_nest[ds] - 1'b1;
                        end
                    end
                    prdt_pkg::FN_FREE_P: begin
                        if (!pv) r_status <= prdt_pkg::ST_NOT_USED;
                        else begin
                            r_per_valid[ps]  <= 1'b0;
                            r_per_reload[ps] <= '0;
                            r_per_count[ps]  <= '0;
                            r_per_prio[ps]   <= '0;
                            r_per_susp[ps]   <= 1'b0;
                            r_per_pend[ps]   <= '0;
                        end
                    end
                    prdt_pkg::FN_FREE_D: begin
                        if (!dv) r_status <= prdt_pkg::ST_NOT_USED;
                        else begin
                            r_dl_valid[ds] <= 1'b0;
                            r_dl_init[ds]  <= '0;
                            r_dl_count[ds] <= '0;
                            r_dl_nest[ds]  <= '0;
                        end
                    end
                    default: r_status <= prdt_pkg::ST_OK;
                endcase
            end
            // One periodic slot per cycle.
            if (i_cmd.per_step) begin
                r_pidx <= r_pidx + 1'b1;
                if (r_per_valid[r_pidx]) begin
                    r_per_count[r_pidx] <= pzero ? r_per_reload[r_pidx] : pdec;
                    if (pzero) begin
                        if (r_per_susp[r_pidx]) begin
                            r_per_susp[r_pidx] <= 1'b0;
                            r_rel <= r_rel + 1'b1;
                            if (r_per_prio[r_pidx] < r_act_prio) r_pre <= 1'b1;
                        end else if (r_per_pend[r_pidx] != prdt_pkg::LevelMax) begin
                            r_per_pend[r_pidx] <= r_per_pend[r_pidx] + 1'b1;
                        end else begin
                            r_sat <= 1'b1;
                        end
                    end
                end
            end
            // One deadline slot per cycle; the last step also forms the result.
            if (i_cmd.dl_step) begin
                r_didx <= r_didx + 1'b1;
                if (dact) begin
                    r_dl_count[r_didx] <= r_dl_count[r_didx] - 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_preempt        <= r_pre && !(r_act_dl && r_act_prio == '0);
                r_still          <= 1'b0;
                r_level          <= '0;
                r_status         <= r_sat ? prdt_pkg::ST_LIMIT : prdt_pkg::ST_OK;
            end
            if (i_cmd.dl_step && dact && r_dl_count[r_didx] == CB'(1)) begin
                r_miss <= r_miss + 1'b1;
            end
        end
    end

    assign o_preempt        = r_preempt;
    assign o_released_count = o_stat.is_tick ? r_rel : 5'd0;
    assign o_new_misses     = o_stat.is_tick ? r_miss : 5'd0;
    assign o_still_ready    = r_still;
    assign o_level          = r_level;
    assign o_status         = r_status;
endmodule

### design/periodic_release_deadline_timer.sv
// Top level of the periodic release and deadline timer.
// Depends on prdt_pkg, prdt_if, prdt_ctrl and prdt_datapath.
//
// One item is taken at a time. A tick walks every periodic slot and then
// every deadline slot, one slot per clock, before its result is shown;
// every other operation is executed in the operation state and then shows
// its result. Once the result is taken the controller returns to idle.
// The sequencing is set by the slot-update logic in the datapath, which
// serves one slot at a time. The result stays valid until taken; no new
// item is accepted until then.
module periodic_release_deadline_timer (
    input logic       i_clk,
    input logic       i_rst_n,
    prdt_in_if.sink   i_in,
    prdt_out_if.source o_out
);
    prdt_pkg::t_cmd  cmd;
    prdt_pkg::t_stat stat;

    prdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    prdt_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_func                (i_in.func),
        .i_slot                (i_in.slot),
        .i_count_value         (i_in.count_value),
        .i_priority_req        (i_in.priority_req),
        .i_active_priority     (i_in.active_priority),
        .i_active_has_deadline (i_in.active_has_deadline),
        .o_preempt             (o_out.preempt),
        .o_released_count      (o_out.released_count),
        .o_new_misses          (o_out.new_misses),
        .o_still_ready         (o_out.still_ready),
        .o_level               (o_out.level),
        .o_status              (o_out.status)
    );
endmodule
